// ----- hdl/spp_pkg.sv -----
// Shared constants, register codes and types of the spread point planner.
package spp_pkg;

   localparam int POS_W          = 20;
   localparam int IDX_W          = 6;
   localparam int CNT_W          = 8;
   localparam int CSR_IDX_W      = 3;
   localparam int MAX_POINTS_DEF = 64;
   localparam int SPACING_FLOOR  = 1000;
   localparam int SPACING_CAP    = 100;

   localparam logic [CSR_IDX_W-1:0] REG_TOP_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLIND_ZONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPACING  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER_UP     = 3'd5;

   typedef logic [POS_W-1:0] height_type;

   typedef struct packed {
      logic       done;
      height_type quotient;
      height_type remainder;
   } div_result_type;

   typedef struct packed {
      logic load;
      logic step;
      logic up;
   } step_ctl_type;

endpackage

// ----- hdl/spp_if.sv -----
// Request, result and register write channel interfaces of the spread point planner.
interface spp_req_if import spp_pkg::*; ();
   logic       valid;
   logic       ready;
   height_type liquid_level;

   modport source (output valid, output liquid_level, input ready);
   modport sink   (input valid, input liquid_level, output ready);
endinterface

interface spp_rsp_if import spp_pkg::*; ();
   logic             valid;
   logic             ready;
   height_type       position;
   logic [IDX_W-1:0] point_index;
   logic             last;
   logic             status;

   modport source (output valid, output position, output point_index, output last,
                   output status, input ready);
   modport sink   (input valid, input position, input point_index, input last,
                   input status, output ready);
endinterface

interface spp_csr_if import spp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   height_type           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/spp_serial_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module spp_serial_div import spp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  height_type     dividend,
   input  height_type     divisor,
   output div_result_type result
);

   localparam int CNT_BITS = $clog2(POS_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   height_type          rem_ff;
   height_type          quo_ff;
   height_type          dvs_ff;

   logic [POS_W:0] shifted;
   logic [POS_W:0] diff;
   logic           fits;
   height_type     rem_in;
   height_type     quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[POS_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = fits ? diff[POS_W-1:0] : shifted[POS_W-1:0];
      quo_in  = {quo_ff[POS_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(POS_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

// ----- hdl/spp_point_step.sv -----
// Stepper that walks the rounded point heights by whole quotient and remainder increments.
module spp_point_step import spp_pkg::*; #(
   parameter int DW = 6
) (
   input  logic          clock,
   input  step_ctl_type  ctl,
   input  height_type    start_pos,
   input  logic [DW-1:0] d,
   input  height_type    qb,
   input  logic [DW-1:0] rb_half,
   output height_type    pos
);

   localparam int RW = DW + 3;

   height_type          pos_ff;
   height_type          qb_ff;
   logic signed [RW-1:0] rem_ff;
   logic [DW:0]         rb_ff;
   logic [DW:0]         two_d_ff;

   logic signed [RW-1:0] sum_up;
   logic signed [RW-1:0] diff_dn;
   logic                 wrap_up;
   logic                 wrap_dn;
   logic signed [RW-1:0] rem_in;
   height_type           pos_in;

   always_comb begin
      sum_up  = rem_ff + $signed({2'b00, rb_ff});
      diff_dn = rem_ff - $signed({2'b00, rb_ff});
      wrap_up = sum_up >= $signed({2'b00, two_d_ff});
      wrap_dn = diff_dn[RW-1];
      if (ctl.up) begin
         rem_in = wrap_up ? sum_up - $signed({2'b00, two_d_ff}) : sum_up;
         pos_in = pos_ff + qb_ff + POS_W'(wrap_up);
      end else begin
         rem_in = wrap_dn ? diff_dn + $signed({2'b00, two_d_ff}) : diff_dn;
         pos_in = pos_ff - qb_ff - POS_W'(wrap_dn);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pos_ff   <= start_pos;
         qb_ff    <= qb;
         rem_ff   <= $signed({3'b000, d});
         rb_ff    <= {rb_half, 1'b0};
         two_d_ff <= {d, 1'b0};
      end else if (ctl.step) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
      end
   end

   assign pos = pos_ff;

endmodule

// ----- hdl/spread_point_planner.sv -----
// Top level of the spread point planner: registers, sequencer and result register.
// A request is taken only while the planner is idle. An invalid request or a single point
// plan loads its result into the result register from the check state, once the result
// register is free. A spread plan of n points runs a check state, two bit-serial divisions
// in the shared divider (band by spacing, then band by n-1) with a setup state between
// them, and then one point per cycle while the result register is free; a stalled result
// register holds the sequence back.
module spread_point_planner import spp_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spp_req_if.sink     req_chan,
   spp_rsp_if.source   rsp_chan,
   spp_csr_if.sink     csr_chan
);

   localparam int DW = $clog2(MAX_POINTS);
   localparam logic [CNT_W-1:0] MAX_REQ = CNT_W'(MAX_POINTS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV1  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_DIV2  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   height_type       top_ff;
   height_type       bottom_ff;
   height_type       blind_ff;
   logic [CNT_W-1:0] count_ff;
   height_type       spacing_ff;
   logic             order_up_ff;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   height_type       level_ff;
   logic [DW-1:0]    d_ff;
   logic [DW-1:0]    d_in;
   logic [DW-1:0]    idx_ff;
   logic [DW-1:0]    idx_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   height_type       position_ff;
   height_type       position_in;
   logic [IDX_W-1:0] index_ff;
   logic [IDX_W-1:0] index_in;
   logic             last_ff;
   logic             last_in;
   logic             status_ff;
   logic             status_in;

   height_type             floor_h;
   height_type             spacing;
   height_type             edge_h;
   height_type             single_pos;
   logic signed [POS_W+1:0] band_s;
   logic [CNT_W-1:0]       req_c;
   logic [CNT_W-1:0]       fit;
   logic [CNT_W-1:0]       n_calc;
   logic                   invalid;
   logic                   single;
   logic                   out_free;
   logic                   out_load;
   logic                   div_start;
   height_type             div_divisor;
   div_result_type         div_res;
   step_ctl_type           step_ctl;
   height_type             step_pos;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff      <= '0;
         bottom_ff   <= '0;
         blind_ff    <= '0;
         count_ff    <= '0;
         spacing_ff  <= POS_W'(SPACING_FLOOR);
         order_up_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_TOP_LIMIT:    top_ff      <= csr_chan.data;
            REG_BOTTOM_LIMIT: bottom_ff   <= csr_chan.data;
            REG_BLIND_ZONE:   blind_ff    <= csr_chan.data;
            REG_POINT_COUNT:  count_ff    <= csr_chan.data[CNT_W-1:0];
            REG_MIN_SPACING:  spacing_ff  <= csr_chan.data;
            REG_ORDER_UP:     order_up_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      floor_h    = (blind_ff > bottom_ff) ? blind_ff : bottom_ff;
      spacing    = (spacing_ff < POS_W'(SPACING_FLOOR)) ? POS_W'(SPACING_FLOOR) : spacing_ff;
      req_c      = (count_ff > MAX_REQ) ? MAX_REQ : count_ff;
      band_s     = $signed({2'b00, level_ff}) - $signed({2'b00, top_ff})
                   - $signed({2'b00, floor_h});
      edge_h     = level_ff - top_ff;
      invalid    = (level_ff == '0) || (count_ff == '0);
      single     = (req_c == CNT_W'(1)) || (level_ff <= spacing)
                   || (band_s < $signed({2'b00, spacing}));
      single_pos = ((level_ff >> 1) < blind_ff) ? blind_ff : (level_ff >> 1);
      if (div_res.quotient >= POS_W'(SPACING_CAP - 1)) begin
         fit = CNT_W'(SPACING_CAP);
      end else begin
         fit = div_res.quotient[CNT_W-1:0] + CNT_W'(1)
               + CNT_W'(div_res.remainder != '0);
      end
      n_calc = (req_c < fit) ? req_c : fit;
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      d_in          = d_ff;
      idx_in        = idx_ff;
      div_start     = 1'b0;
      div_divisor   = spacing;
      step_ctl.load = 1'b0;
      step_ctl.step = 1'b0;
      step_ctl.up   = order_up_ff;
      out_load      = 1'b0;
      position_in   = step_pos;
      index_in      = IDX_W'(idx_ff);
      last_in       = (idx_ff == d_ff);
      status_in     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (invalid || single) begin
               if (out_free) begin
                  out_load    = 1'b1;
                  position_in = invalid ? '0 : single_pos;
                  index_in    = '0;
                  last_in     = 1'b1;
                  status_in   = invalid;
                  state_in    = ST_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_res.done) begin
               d_in     = DW'(n_calc - CNT_W'(1));
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            div_start   = 1'b1;
            div_divisor = POS_W'(d_ff);
            state_in    = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_res.done) begin
               step_ctl.load = 1'b1;
               idx_in        = '0;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               step_ctl.step = 1'b1;
               idx_in        = idx_ff + 1'b1;
               if (idx_ff == d_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         level_ff <= req_chan.liquid_level;
      end
      d_ff   <= d_in;
      idx_ff <= idx_in;
      if (out_load) begin
         position_ff <= position_in;
         index_ff    <= index_in;
         last_ff     <= last_in;
         status_ff   <= status_in;
      end
   end

   spp_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (band_s[POS_W-1:0]),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   spp_point_step #(
      .DW (DW)
   ) u_step (
      .clock     (clock),
      .ctl       (step_ctl),
      .start_pos (order_up_ff ? floor_h : edge_h),
      .d         (d_ff),
      .qb        (div_res.quotient),
      .rb_half   (div_res.remainder[DW-1:0]),
      .pos       (step_pos)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.position    = position_ff;
   assign rsp_chan.point_index = index_ff;
   assign rsp_chan.last        = last_ff;
   assign rsp_chan.status      = status_ff;

`ifndef ASSERT_OFF
   a_invalid_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff |-> last_ff && position_ff == '0 && index_ff == '0)
      else $error("Invalid plan result is not a lone zero point.");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff <= d_ff)
      else $error("Point index ran past the end of the plan.");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV1 || state_ff == ST_DIV2)
      else $error("Divider finished outside a division step.");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == ST_CHECK)
      else $error("Accepted request was not checked in the next cycle.");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the spread point planner with its own plan predictor.
`timescale 1ns / 1ps

module tb_top import spp_pkg::*; ();

   localparam int  HALF_PERIOD   = 5;
   localparam int  RESET_CYCLES  = 5;
   localparam int  PHASES        = 20;
   localparam int  PHASE_ITEMS   = 25;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  DRAIN_CYCLES  = 60;
   localparam int  CYCLE_LIMIT   = 3_000_000;
   localparam int  SHOWN_ERRORS  = 10;
   localparam longint LEVEL_MAX  = 64'hFFFFF;

   typedef struct {
      height_type       position;
      logic [IDX_W-1:0] point_index;
      logic             last;
      logic             status;
   } plan_point_type;

   logic clock;
   logic reset;

   spp_req_if req_bus ();
   spp_rsp_if rsp_bus ();
   spp_csr_if csr_bus ();

   spread_point_planner u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   height_type       cfg_top;
   height_type       cfg_bottom;
   height_type       cfg_blind;
   logic [CNT_W-1:0] cfg_count;
   height_type       cfg_spacing;
   logic             cfg_order_up;

   height_type     levels_to_send[$];
   plan_point_type planned_points[$];

   bit      req_taken;
   int      gap_left;
   int      burst_left;
   int      stall_left;
   int      rx_mode;
   longint  rx_cycle;
   longint  cycle_count;
   int      mismatches;

   always #HALF_PERIOD clock = ~clock;

   function automatic void plan_points(input height_type level_in);
      longint         level_h, floor_h, spacing, band, fit, n, edge_h, d, num, p, k;
      plan_point_type pt;
      level_h = level_in;
      floor_h = (cfg_blind > cfg_bottom) ? cfg_blind : cfg_bottom;
      spacing = (cfg_spacing < SPACING_FLOOR) ? SPACING_FLOOR : cfg_spacing;
      if (level_h == 0 || cfg_count == 0) begin
         pt.position    = '0;
         pt.point_index = '0;
         pt.last        = 1'b1;
         pt.status      = 1'b1;
         planned_points.push_back(pt);
         return;
      end
      n    = (cfg_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_count;
      band = level_h - longint'(cfg_top) - floor_h;
      if (level_h <= spacing || n == 1 || band < spacing) begin
         p = level_h / 2;
         if (p < cfg_blind) p = cfg_blind;
         pt.position    = height_type'(p);
         pt.point_index = '0;
         pt.last        = 1'b1;
         pt.status      = 1'b0;
         planned_points.push_back(pt);
         return;
      end
      fit = band / spacing + (((band % spacing) == 0) ? 1 : 2);
      if (fit > SPACING_CAP) fit = SPACING_CAP;
      if (n > fit) n = fit;
      if (n < 2) n = 2;
      edge_h = level_h - longint'(cfg_top);
      d      = n - 1;
      for (longint i = 0; i < n; i++) begin
         k   = cfg_order_up ? (d - i) : i;
         num = edge_h * d - band * k;
         if (num < 0) num = 0;
         p = (2 * num + d) / (2 * d);
         if (p < floor_h) p = floor_h;
         if (p > edge_h) p = edge_h;
         pt.position    = height_type'(p);
         pt.point_index = i[IDX_W-1:0];
         pt.last        = (i == d);
         pt.status      = 1'b0;
         planned_points.push_back(pt);
      end
   endfunction

   // Requests and result checks are both taken at the rising edge.
   always @(posedge clock) begin
      plan_point_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (req_taken) plan_points(req_bus.liquid_level);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (planned_points.size() == 0) begin
               if (mismatches < SHOWN_ERRORS)
                  $display("unexpected point: position %0d index %0d last %0b status %0b",
                           rsp_bus.position, rsp_bus.point_index, rsp_bus.last,
                           rsp_bus.status);
               mismatches++;
            end else begin
               want = planned_points.pop_front();
               if (rsp_bus.position !== want.position ||
                   rsp_bus.point_index !== want.point_index ||
                   rsp_bus.last !== want.last || rsp_bus.status !== want.status) begin
                  if (mismatches < SHOWN_ERRORS)
                     $display("point mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                              want.position, want.point_index, want.last, want.status,
                              rsp_bus.position, rsp_bus.point_index, rsp_bus.last,
                              rsp_bus.status);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         req_bus.valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_bus.valid <= 1'b0;
      end else if (levels_to_send.size() > 0) begin
         req_bus.valid        <= 1'b1;
         req_bus.liquid_level <= levels_to_send.pop_front();
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
               gap_left = 0;
            else if ($urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 80);
            else
               gap_left = $urandom_range(1, 5);
         end else begin
            burst_left--;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_bus.ready <= (rx_cycle % 4 != 3);
            end
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 20);
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input height_type val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_TOP_LIMIT:    cfg_top      = val;
         REG_BOTTOM_LIMIT: cfg_bottom   = val;
         REG_BLIND_ZONE:   cfg_blind    = val;
         REG_POINT_COUNT:  cfg_count    = val[CNT_W-1:0];
         REG_MIN_SPACING:  cfg_spacing  = val;
         REG_ORDER_UP:     cfg_order_up = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input height_type top, input height_type bottom,
                             input height_type blind, input logic [CNT_W-1:0] count,
                             input height_type spacing, input logic up);
      write_reg(REG_TOP_LIMIT, top);
      write_reg(REG_BOTTOM_LIMIT, bottom);
      write_reg(REG_BLIND_ZONE, blind);
      write_reg(REG_POINT_COUNT, height_type'(count));
      write_reg(REG_MIN_SPACING, spacing);
      write_reg(REG_ORDER_UP, height_type'(up));
   endtask

   task automatic wait_idle();
      while (levels_to_send.size() != 0 || req_bus.valid || planned_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic height_type pick_height(input int unsigned typical_max);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return height_type'($urandom_range(0, LEVEL_MAX));
         default: return height_type'($urandom_range(0, typical_max));
      endcase
   endfunction

   task automatic random_config();
      logic [CNT_W-1:0] count;
      height_type       spacing;
      case ($urandom_range(0, 9))
         0:       count = '0;
         1:       count = 8'd1;
         2:       count = CNT_W'($urandom_range(65, 255));
         default: count = CNT_W'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 9))
         0:       spacing = height_type'($urandom_range(0, SPACING_FLOOR));
         1:       spacing = height_type'($urandom_range(0, LEVEL_MAX));
         2:       spacing = height_type'(LEVEL_MAX);
         default: spacing = height_type'($urandom_range(SPACING_FLOOR, 60000));
      endcase
      set_config(pick_height(20000), pick_height(30000), pick_height(30000), count,
                 spacing, 1'($urandom_range(0, 1)));
   endtask

   function automatic height_type random_level();
      longint floor_h, spacing, lo;
      floor_h = (cfg_blind > cfg_bottom) ? cfg_blind : cfg_bottom;
      spacing = (cfg_spacing < SPACING_FLOOR) ? SPACING_FLOOR : cfg_spacing;
      lo      = longint'(cfg_top) + floor_h + spacing;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return height_type'($urandom_range(0, LEVEL_MAX));
         2:       return height_type'($urandom_range(1, 2 * SPACING_FLOOR));
         default: begin
            if (lo > LEVEL_MAX) return height_type'($urandom_range(0, LEVEL_MAX));
            return height_type'($urandom_range(lo, LEVEL_MAX));
         end
      endcase
   endfunction

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.liquid_level = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      cfg_top      = '0;
      cfg_bottom   = '0;
      cfg_blind    = '0;
      cfg_count    = '0;
      cfg_spacing  = height_type'(SPACING_FLOOR);
      cfg_order_up = 1'b0;
      req_taken    = 1'b0;
      gap_left     = 0;
      burst_left   = 0;
      stall_left   = 0;
      rx_mode      = 0;
      rx_cycle     = 0;
      cycle_count  = 0;
      mismatches   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero count after reset rejects every request.
      levels_to_send = '{height_type'(5000), height_type'(0)};
      wait_idle();

      set_config('0, '0, '0, 8'd255, '0, 1'b0);
      levels_to_send = '{height_type'(0), height_type'(1), height_type'(1000),
                         height_type'(2000), height_type'(LEVEL_MAX)};
      wait_idle();

      set_config(height_type'(500), height_type'(1000), height_type'(3000), 8'd1,
                 height_type'(1000), 1'b1);
      levels_to_send = '{height_type'(100000), height_type'(4000)};
      wait_idle();

      set_config(height_type'(500), height_type'(1000), height_type'(3000), 8'd65,
                 height_type'(1000), 1'b1);
      levels_to_send = '{height_type'(4500), height_type'(100000), height_type'(2000)};
      wait_idle();

      set_config(height_type'(LEVEL_MAX), '0, '0, 8'd2, height_type'(1000), 1'b0);
      levels_to_send = '{height_type'(LEVEL_MAX), height_type'(1)};
      wait_idle();

      set_config('0, height_type'(LEVEL_MAX), '0, 8'd5, height_type'(LEVEL_MAX), 1'b0);
      levels_to_send = '{height_type'(LEVEL_MAX)};
      wait_idle();

      set_config('0, '0, '0, 8'd10, height_type'(1000), 1'b0);
      levels_to_send = '{height_type'(9000), height_type'(9001), height_type'(12345)};
      wait_idle();

      set_config('0, '0, height_type'(LEVEL_MAX), 8'd64, height_type'(1000), 1'b1);
      levels_to_send = '{height_type'(LEVEL_MAX)};
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         random_config();
         for (int i = 0; i < PHASE_ITEMS; i++) levels_to_send.push_back(random_level());
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && planned_points.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/spp_pkg.sv
hdl/spp_if.sv
hdl/spp_serial_div.sv
hdl/spp_point_step.sv
hdl/spread_point_planner.sv
verif/tb_top.sv
